// ===== hw/rtl/sbsm_pkg.sv =====
// Shared types, codes and bank arithmetic helpers for the serial bank switch mapper.
package sbsm_pkg;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int ACTION_W     = 2;
  localparam int OFFSET_W     = 19;
  localparam int CHR_BASE_W   = 18;
  localparam int BANK_W       = 5;
  localparam int COUNT_W      = 6;
  localparam int MIRROR_W     = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int PRG_BANK_SHIFT = 14;  // 16 KiB program banks
  localparam int CHR_BANK_SHIFT = 12;  // 4 KiB pattern banks

  // Actions carried by an input transaction.
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRG_MAP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHR_MAP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_MIRROR    = 2'd1;

  // Header mirroring codes.
  localparam logic [MIRROR_W-1:0] HDR_VERTICAL   = 2'd0;
  localparam logic [MIRROR_W-1:0] HDR_HORIZONTAL = 2'd1;

  // Reported mirroring codes.
  localparam logic [MIRROR_W-1:0] MIR_VERTICAL   = 2'd0;
  localparam logic [MIRROR_W-1:0] MIR_HORIZONTAL = 2'd1;
  localparam logic [MIRROR_W-1:0] MIR_SINGLE     = 2'd2;

  // Serial register target selected by address bits 14..13.
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // Control register bit positions.
  localparam int CTRL_MIR_ENABLE = 1;
  localparam int CTRL_MIR_HORZ   = 0;
  localparam int CTRL_PRG_LOW    = 2;
  localparam int CTRL_PRG_16K    = 3;
  localparam int CTRL_CHR_4K     = 4;

  localparam logic [BANK_W-1:0]  CTRL_RESET_SET = 5'h0C;
  localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 6'd8;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;
  } sbsm_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0]   prg_low;
    logic [OFFSET_W-1:0]   prg_high;
    logic [CHR_BASE_W-1:0] chr_low;
    logic [CHR_BASE_W-1:0] chr_high;
  } sbsm_bases_t;

  // Control mirroring bits for a header mirroring code.
  function automatic logic [1:0] mirror_bits(input logic [MIRROR_W-1:0] hdr);
    logic [1:0] bits;
    if (hdr == HDR_VERTICAL) begin
      bits = 2'b10;
    end else if (hdr == HDR_HORIZONTAL) begin
      bits = 2'b11;
    end else begin
      bits = 2'b00;
    end
    return bits;
  endfunction

  // Base of the last program bank; a count of zero wraps to bank 31.
  function automatic logic [OFFSET_W-1:0] last_bank_base(input logic [COUNT_W-1:0] count);
    logic [BANK_W-1:0] last;
    last = count[BANK_W-1:0] - BANK_W'(1);
    return {last, {PRG_BANK_SHIFT{1'b0}}};
  endfunction

endpackage

// ===== hw/rtl/serial_bank_switch_mapper_top.sv =====
// Top level of the serial bank switch mapper: input register, mapper state and result register.
//
// This block models a five-bit serially loaded bank switching mapper. Each input
// transaction is a CPU write to the 0x8000-0xFFFF window, a program address translation
// or a pattern address translation, and each one produces exactly one result
// transaction carrying the ROM byte offset, the mirroring after the step and a flag
// set when a write completed the fifth serial bit. A transaction is registered on
// acceptance and processed in the following cycle unless the output register holds a
// stalled result. When it is processed, the mapper state is read and updated and the
// result is captured in the output register, which raises out_valid. The block sustains
// one transaction per cycle as long as the output side does not stall. The input
// register and the output register decouple the two sides: a new transaction is taken
// while a finished result still waits, and in_stall rises only when both registers are
// full and out_stall is high. The configuration port is always ready; the bank count
// and header mirroring should be written only while no transaction is in flight.
module serial_bank_switch_mapper_top (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sbsm_pkg::ACTION_W-1:0]        in_action,
  input  logic [sbsm_pkg::ADDR_W-1:0]          in_address,
  input  logic [sbsm_pkg::DATA_W-1:0]          in_write_data,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sbsm_pkg::OFFSET_W-1:0]        out_rom_offset,
  output logic [sbsm_pkg::MIRROR_W-1:0]        out_mirror_mode,
  output logic                                 out_register_loaded,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sbsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                              in_v_r, in_v_nxt;
  sbsm_pkg::sbsm_item_t              in_item_r;
  logic                              out_v_r, out_v_nxt;
  logic [sbsm_pkg::OFFSET_W-1:0]     out_offset_r;
  logic [sbsm_pkg::MIRROR_W-1:0]     out_mirror_r;
  logic                              out_loaded_r;

  logic                              accept;
  logic                              advance;
  sbsm_pkg::sbsm_bases_t             bases;
  logic [sbsm_pkg::MIRROR_W-1:0]     mirror_after;
  logic                              loaded;
  logic [sbsm_pkg::OFFSET_W-1:0]     rom_offset;

  // The held transaction moves on whenever the output register is empty or being drained.
  assign advance   = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.action     <= in_action;
      in_item_r.address    <= in_address;
      in_item_r.write_data <= in_write_data;
    end
    if (advance) begin
      out_offset_r <= rom_offset;
      out_mirror_r <= mirror_after;
      out_loaded_r <= loaded;
    end
  end

  // Mapper state is updated in the same cycle as the transaction is moved to the output.
  sbsm_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .proc         (advance),
    .item         (in_item_r),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bases        (bases),
    .mirror_after (mirror_after),
    .loaded       (loaded)
  );

  // Translations use the bases as they stand before this transaction.
  sbsm_xlate u_xlate (
    .item       (in_item_r),
    .bases      (bases),
    .rom_offset (rom_offset)
  );

  assign out_valid           = out_v_r;
  assign out_rom_offset      = out_offset_r;
  assign out_mirror_mode     = out_mirror_r;
  assign out_register_loaded = out_loaded_r;

endmodule

// ===== hw/rtl/sbsm_state.sv =====
// Mapper state: serial loader, bank registers, bank bases and configuration writes.
module sbsm_state (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                proc,
  input  sbsm_pkg::sbsm_item_t                item,
  input  logic                                cfg_we,
  input  logic [sbsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output sbsm_pkg::sbsm_bases_t               bases,
  output logic [sbsm_pkg::MIRROR_W-1:0]       mirror_after,
  output logic                                loaded
);

  logic [3:0]                        shift_bits_r, shift_bits_nxt;
  logic [2:0]                        shift_count_r, shift_count_nxt;
  logic [sbsm_pkg::BANK_W-1:0]       control_r, control_nxt;
  logic [sbsm_pkg::BANK_W-1:0]       chr0_r, chr0_nxt;
  logic [sbsm_pkg::BANK_W-1:0]       chr1_r, chr1_nxt;
  logic [sbsm_pkg::BANK_W-1:0]       prg_r, prg_nxt;
  logic [sbsm_pkg::COUNT_W-1:0]      prg_count_r, prg_count_nxt;
  sbsm_pkg::sbsm_bases_t             bases_r, bases_nxt;

  logic                              is_write;
  logic [1:0]                        sel;
  logic [sbsm_pkg::BANK_W-1:0]       value;
  logic                              commit;

  assign is_write = proc && (item.action == sbsm_pkg::ACT_WRITE) && item.address[15];
  assign sel      = item.address[14:13];
  assign value    = {item.write_data[0], shift_bits_r};
  assign commit   = is_write && !item.write_data[7] && (shift_count_r == 3'd4);

  always_comb begin
    shift_bits_nxt  = shift_bits_r;
    shift_count_nxt = shift_count_r;
    control_nxt     = control_r;
    chr0_nxt        = chr0_r;
    chr1_nxt        = chr1_r;
    prg_nxt         = prg_r;
    prg_count_nxt   = prg_count_r;
    bases_nxt       = bases_r;

    if (is_write) begin
      if (item.write_data[7]) begin
        shift_bits_nxt  = '0;
        shift_count_nxt = '0;
        case (sel)
          sbsm_pkg::SEL_CONTROL: control_nxt = control_r | sbsm_pkg::CTRL_RESET_SET;
          sbsm_pkg::SEL_CHR0:    chr0_nxt = '0;
          sbsm_pkg::SEL_CHR1:    chr1_nxt = '0;
          default:               prg_nxt = '0;
        endcase
      end else if (!commit) begin
        shift_bits_nxt[shift_count_r[1:0]] = item.write_data[0];
        shift_count_nxt = shift_count_r + 3'd1;
      end else begin
        shift_bits_nxt  = '0;
        shift_count_nxt = '0;
        case (sel)
          sbsm_pkg::SEL_CONTROL: control_nxt = value;
          sbsm_pkg::SEL_CHR0:    chr0_nxt = value;
          sbsm_pkg::SEL_CHR1:    chr1_nxt = value;
          default:               prg_nxt = value;
        endcase
        // Bases change only on a bank commit or a bank count configuration write.
        if (sel == sbsm_pkg::SEL_CHR0 || sel == sbsm_pkg::SEL_CHR1) begin
          if (control_r[sbsm_pkg::CTRL_CHR_4K]) begin
            bases_nxt.chr_low  = {1'b0, chr0_nxt, {sbsm_pkg::CHR_BANK_SHIFT{1'b0}}};
            bases_nxt.chr_high = {1'b0, chr1_nxt, {sbsm_pkg::CHR_BANK_SHIFT{1'b0}}};
          end else begin
            bases_nxt.chr_low  = {1'b0, chr0_nxt[4:1], 1'b0,
                                  {sbsm_pkg::CHR_BANK_SHIFT{1'b0}}};
            bases_nxt.chr_high = {1'b0, chr0_nxt[4:1], 1'b1,
                                  {sbsm_pkg::CHR_BANK_SHIFT{1'b0}}};
          end
        end else if (sel == sbsm_pkg::SEL_PRG) begin
          if (!control_r[sbsm_pkg::CTRL_PRG_16K]) begin
            bases_nxt.prg_low  = {prg_nxt[4:1], 1'b0, {sbsm_pkg::PRG_BANK_SHIFT{1'b0}}};
            bases_nxt.prg_high = {prg_nxt[4:1], 1'b1, {sbsm_pkg::PRG_BANK_SHIFT{1'b0}}};
          end else if (control_r[sbsm_pkg::CTRL_PRG_LOW]) begin
            bases_nxt.prg_low  = {prg_nxt, {sbsm_pkg::PRG_BANK_SHIFT{1'b0}}};
            bases_nxt.prg_high = sbsm_pkg::last_bank_base(prg_count_r);
          end else begin
            bases_nxt.prg_low  = '0;
            bases_nxt.prg_high = {prg_nxt, {sbsm_pkg::PRG_BANK_SHIFT{1'b0}}};
          end
        end
      end
    end

    if (cfg_we) begin
      if (cfg_index == sbsm_pkg::CFG_PRG_BANK_COUNT) begin
        prg_count_nxt      = cfg_data;
        bases_nxt.prg_high = sbsm_pkg::last_bank_base(cfg_data);
      end else if (cfg_index == sbsm_pkg::CFG_INIT_MIRROR) begin
        control_nxt[1:0] = sbsm_pkg::mirror_bits(cfg_data[sbsm_pkg::MIRROR_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_bits_r     <= '0;
      shift_count_r    <= '0;
      control_r        <= {3'b011, sbsm_pkg::mirror_bits(sbsm_pkg::HDR_VERTICAL)};
      chr0_r           <= '0;
      chr1_r           <= '0;
      prg_r            <= '0;
      prg_count_r      <= sbsm_pkg::PRG_COUNT_RESET;
      bases_r.prg_low  <= '0;
      bases_r.prg_high <= sbsm_pkg::last_bank_base(sbsm_pkg::PRG_COUNT_RESET);
      bases_r.chr_low  <= '0;
      bases_r.chr_high <= {5'b0, 1'b1, {sbsm_pkg::CHR_BANK_SHIFT{1'b0}}};
    end else begin
      shift_bits_r  <= shift_bits_nxt;
      shift_count_r <= shift_count_nxt;
      control_r     <= control_nxt;
      chr0_r        <= chr0_nxt;
      chr1_r        <= chr1_nxt;
      prg_r         <= prg_nxt;
      prg_count_r   <= prg_count_nxt;
      bases_r       <= bases_nxt;
    end
  end

  assign bases   = bases_r;
  assign loaded  = commit;

  always_comb begin
    if (!control_nxt[sbsm_pkg::CTRL_MIR_ENABLE]) begin
      mirror_after = sbsm_pkg::MIR_SINGLE;
    end else if (control_nxt[sbsm_pkg::CTRL_MIR_HORZ]) begin
      mirror_after = sbsm_pkg::MIR_HORIZONTAL;
    end else begin
      mirror_after = sbsm_pkg::MIR_VERTICAL;
    end
  end

endmodule

// ===== hw/rtl/sbsm_xlate.sv =====
// Address translation of program and pattern accesses into ROM byte offsets.
module sbsm_xlate (
  input  sbsm_pkg::sbsm_item_t               item,
  input  sbsm_pkg::sbsm_bases_t              bases,
  output logic [sbsm_pkg::OFFSET_W-1:0]      rom_offset
);

  logic [sbsm_pkg::OFFSET_W-1:0] prg_base;
  logic [sbsm_pkg::OFFSET_W-1:0] chr_base;

  assign prg_base = item.address[14] ? bases.prg_high : bases.prg_low;
  assign chr_base = item.address[12] ? {1'b0, bases.chr_high} : {1'b0, bases.chr_low};

  always_comb begin
    case (item.action)
      sbsm_pkg::ACT_PRG_MAP: begin
        rom_offset = prg_base + {5'b0, item.address[13:0]};
      end
      sbsm_pkg::ACT_CHR_MAP: begin
        // Pattern addresses of 0x2000 and above map to nothing.
        if (item.address[15:13] == 3'b000) begin
          rom_offset = chr_base + {7'b0, item.address[11:0]};
        end else begin
          rom_offset = '0;
        end
      end
      default: rom_offset = '0;
    endcase
  end

endmodule
